// File: design/hcd_pkg.sv
// package for the chunked body decoder: sizes, codes and shared types
// no dependencies; imported by hcd_size_parse, http_chunked_body_decoder and the testbench
`timescale 1ns / 1ps

package hcd_pkg;

  localparam int MAX_LINE    = 10;
  localparam int SIZE_BITS   = 32;
  localparam int LINE_CNT_W  = 4;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  typedef enum logic [1:0] {
    KIND_LINE = 2'd0,
    KIND_PAY  = 2'd1,
    KIND_END  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    MODE_LINE = 4'b0001,
    MODE_DATA = 4'b0010,
    MODE_DONE = 4'b0100,
    MODE_ERR  = 4'b1000
  } mode_t;

  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_STOP   = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic [SIZE_BITS-1:0]   accum;
  } parse_t;

endpackage

// File: design/hcd_size_parse.sv
// hex size parser step: whitespace skip, digit accumulate, saturation
// depends on hcd_pkg
`timescale 1ns / 1ps

module hcd_size_parse (
  input  logic [7:0]     data_byte,
  input  hcd_pkg::parse_t cur,
  output hcd_pkg::parse_t nxt
);
  import hcd_pkg::*;

  logic       is_digit;
  logic       is_ws;
  logic [3:0] digit_val;
  phase_t     phase_new;

  always_comb begin
    is_digit  = 1'b1;
    digit_val = 4'd0;
    case (data_byte) inside
      [8'h30:8'h39]: digit_val = data_byte[3:0];
      [8'h61:8'h66]: digit_val = 4'(data_byte - 8'h57);
      [8'h41:8'h46]: digit_val = 4'(data_byte - 8'h37);
      default:       is_digit  = 1'b0;
    endcase
    is_ws = (data_byte == 8'h20) || ((data_byte >= 8'h09) && (data_byte <= 8'h0d));
  end

  always_comb begin
    phase_new = cur.phase;
    if ((cur.phase == PH_SKIP) && !is_ws) begin
      phase_new = is_digit ? PH_DIGITS : PH_STOP;
    end else if ((cur.phase == PH_DIGITS) && !is_digit) begin
      phase_new = PH_STOP;
    end

    nxt.phase = phase_new;
    nxt.accum = cur.accum;
    if ((phase_new == PH_DIGITS) && is_digit) begin
      // saturate once another nibble would overflow
      if (cur.accum[SIZE_BITS-1 -: 4] != 4'd0) begin
        nxt.accum = '1;
      end else begin
        nxt.accum = {cur.accum[SIZE_BITS-5:0], digit_val};
      end
    end
  end

endmodule

// File: design/http_chunked_body_decoder.sv
// each accepted input beat gives its result beat from the result register in the next cycle
// throughput: one byte per cycle; in_ready only falls while a result is held and out_ready is low
// the decode state and the result register update in the same cycle as the accept
// reset (rst_n, synchronous, active low) returns to size-line mode with empty line state
// top level of the chunked body decoder; depends on hcd_pkg and hcd_size_parse
`timescale 1ns / 1ps

module http_chunked_body_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_chunk_last
);
  import hcd_pkg::*;

  // decode state
  mode_t                   mode_r, mode_nxt;
  logic [LINE_CNT_W-1:0]   line_cnt_r, line_cnt_nxt;
  logic                    prev_cr_r, prev_cr_nxt;
  parse_t                  parse_r, parse_nxt;
  logic [SIZE_BITS-1:0]    remain_r, remain_nxt;

  // result register
  logic                    out_valid_r, out_valid_nxt;
  kind_t                   kind_r, kind_nxt;
  logic [7:0]              byte_r, byte_nxt;
  logic                    last_r, last_nxt;

  parse_t                  parse_step;
  logic                    in_fire;
  logic [LINE_CNT_W-1:0]   cnt_inc;
  logic [SIZE_BITS-1:0]    remain_dec;
  logic                    line_ends;

  // the result register frees up in the same cycle it is taken
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  hcd_size_parse u_parse (
    .data_byte (in_byte),
    .cur       (parse_r),
    .nxt       (parse_step)
  );

  assign cnt_inc    = line_cnt_r + LINE_CNT_W'(1);
  assign remain_dec = (remain_r == '0) ? '0 : remain_r - SIZE_BITS'(1);
  // a bare cr lf at the start of a line is whitespace, not a line end
  assign line_ends  = (cnt_inc > LINE_CNT_W'(2)) && prev_cr_r && (in_byte == CHAR_LF);

  always_comb begin
    mode_nxt      = mode_r;
    line_cnt_nxt  = line_cnt_r;
    prev_cr_nxt   = prev_cr_r;
    parse_nxt     = parse_r;
    remain_nxt    = remain_r;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (in_fire) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_LINE;
      byte_nxt      = 8'd0;
      last_nxt      = 1'b0;
      case (mode_r)
        MODE_DONE: begin
          kind_nxt = KIND_END;
        end
        MODE_ERR: begin
          kind_nxt = KIND_ERR;
        end
        MODE_DATA: begin
          // payload passes straight through
          kind_nxt   = KIND_PAY;
          byte_nxt   = in_byte;
          remain_nxt = remain_dec;
          if (remain_dec == '0) begin
            last_nxt = 1'b1;
            mode_nxt = MODE_LINE;
          end
        end
        MODE_LINE: begin
          if (line_cnt_r >= LINE_CNT_W'(MAX_LINE)) begin
            // over-long size line, byte is accepted but not parsed
            mode_nxt = MODE_ERR;
            kind_nxt = KIND_ERR;
          end else if (line_ends) begin
            line_cnt_nxt    = '0;
            prev_cr_nxt     = 1'b0;
            parse_nxt.phase = PH_SKIP;
            parse_nxt.accum = '0;
            if (parse_step.accum == '0) begin
              mode_nxt = MODE_DONE;
              kind_nxt = KIND_END;
            end else begin
              remain_nxt = parse_step.accum;
              mode_nxt   = MODE_DATA;
            end
          end else begin
            line_cnt_nxt = cnt_inc;
            prev_cr_nxt  = (in_byte == CHAR_CR);
            parse_nxt    = parse_step;
          end
        end
        default: begin
          mode_nxt = MODE_ERR;
          kind_nxt = KIND_ERR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_LINE;
      line_cnt_r      <= '0;
      prev_cr_r       <= 1'b0;
      parse_r.phase   <= PH_SKIP;
      parse_r.accum   <= '0;
      remain_r        <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      mode_r          <= mode_nxt;
      line_cnt_r      <= line_cnt_nxt;
      prev_cr_r       <= prev_cr_nxt;
      parse_r         <= parse_nxt;
      remain_r        <= remain_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_byte       = byte_r;
  assign out_chunk_last = last_r;

  // done and error are sticky
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_DONE |=> mode_r == MODE_DONE)
    else $error("done state left");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_ERR |=> mode_r == MODE_ERR)
    else $error("error state left");

  // a byte beyond the line limit raises the error result
  a_line_limit: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && mode_r == MODE_LINE && line_cnt_r >= LINE_CNT_W'(MAX_LINE)
    |=> mode_r == MODE_ERR && out_valid_r && kind_r == KIND_ERR)
    else $error("line limit not enforced");

  // the last payload byte of a chunk returns to line mode
  a_chunk_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && mode_r == MODE_DATA && remain_r == SIZE_BITS'(1)
    |=> mode_r == MODE_LINE && last_r && kind_r == KIND_PAY)
    else $error("chunk end missed");

  // only payload beats carry data or the chunk end mark
  a_pay_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r != KIND_PAY |-> byte_r == 8'd0 && !last_r)
    else $error("non-payload beat carries data");

endmodule

// File: tb/sv/http_chunked_body_decoder_tb.sv
// self-checking testbench for the chunked body decoder: directed lines, random chunks, stalls
// depends on hcd_pkg and http_chunked_body_decoder; predicts every result beat in step with input
`timescale 1ns / 1ps

module http_chunked_body_decoder_tb;
  import hcd_pkg::*;

  // whitespace bytes that the size parse skips, besides cr and lf
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam int LONG_HOLD = 60;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_chunk_last;

  // predicted decoder state, mirrors the block from reset onwards
  mode_t                p_mode  = MODE_LINE;
  logic [3:0]           p_count = '0;
  logic                 p_cr    = 1'b0;
  phase_t               p_phase = PH_SKIP;
  logic [SIZE_BITS-1:0] p_accum = '0;
  logic [SIZE_BITS-1:0] p_left  = '0;

  beat_t exp_beats[$];
  int    errors = 0;
  int    beats_seen = 0;
  int    items_sent = 0;

  // idling knobs, percentages per cycle
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // long receiver hold-off: the test bumps hold_asks, the receiver counts it down
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  http_chunked_body_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_chunk_last (out_chunk_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int hex_digit(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    return -1;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SP) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  // advances the predicted state by one accepted byte and returns its result beat
  function automatic beat_t predict_beat(input logic [7:0] b);
    beat_t                r;
    int                   d;
    logic                 ends;
    logic [SIZE_BITS-1:0] line_size;
    r.kind = KIND_LINE;
    r.data = 8'h00;
    r.last = 1'b0;
    d = hex_digit(b);
    case (p_mode)
      MODE_DONE: r.kind = KIND_END;
      MODE_ERR:  r.kind = KIND_ERR;
      MODE_DATA: begin
        r.kind = KIND_PAY;
        r.data = b;
        if (p_left != 0) p_left = p_left - 1'b1;
        if (p_left == 0) begin
          r.last = 1'b1;
          p_mode = MODE_LINE;
        end
      end
      default: begin
        if (p_count >= MAX_LINE) begin
          // line full without an end: sticky error, byte accepted but not parsed
          p_mode = MODE_ERR;
          r.kind = KIND_ERR;
        end else begin
          if (p_phase == PH_SKIP && !is_space(b)) begin
            p_phase = (d >= 0) ? PH_DIGITS : PH_STOP;
          end else if (p_phase == PH_DIGITS && d < 0) begin
            p_phase = PH_STOP;
          end
          if (p_phase == PH_DIGITS && d >= 0) begin
            // saturate rather than wrap once the next shift would overflow
            if (p_accum > ({SIZE_BITS{1'b1}} >> 4)) p_accum = {SIZE_BITS{1'b1}};
            else p_accum = (p_accum << 4) | SIZE_BITS'(d);
          end
          p_count = p_count + 1'b1;
          ends = (p_count > 2) && p_cr && (b == CHAR_LF);
          p_cr = (b == CHAR_CR);
          if (ends) begin
            line_size = p_accum;
            p_count = '0;
            p_cr = 1'b0;
            p_phase = PH_SKIP;
            p_accum = '0;
            if (line_size == 0) begin
              p_mode = MODE_DONE;
              r.kind = KIND_END;
            end else begin
              p_left = line_size;
              p_mode = MODE_DATA;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on result beat %0d: %s got %0h expected %0h",
             beats_seen, what, got, want);
    errors++;
  endtask

  // one input beat; valid stays high across back-to-back beats
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_beats.push_back(predict_beat(b));
    items_sent++;
  endtask

  task automatic send_line(input string body);
    for (int i = 0; i < body.len(); i++) send_byte(body[i]);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
  endtask

  // sender pauses until every predicted beat has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (exp_beats.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'("0" + v);
    return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  // a well-formed size line for len followed by its payload; noisy adds a junk tail
  task automatic send_chunk(input int len, input bit noisy);
    logic [7:0] line[$];
    logic [7:0] c;
    int         nd;
    int         pad;
    int         tail_n;
    int         k;
    // at most two leading whitespace bytes, so cr lf there can never end the line
    repeat ($urandom_range(0, 2)) begin
      k = $urandom_range(0, 5);
      line.push_back((k == 0) ? CHAR_SP : 8'(8 + k));
    end
    nd = (len < 16) ? 1 : (len < 256) ? 2 : 3;
    pad = $urandom_range(0, 3 - nd);
    repeat (pad) line.push_back("0");
    for (int i = nd - 1; i >= 0; i--) line.push_back(hex_char((len >> (4 * i)) & 15));
    if (noisy) begin
      // extension or garbage after the digits, never a cr lf pair
      tail_n = $urandom_range(0, MAX_LINE - 2 - line.size());
      for (int i = 0; i < tail_n; i++) begin
        if (i == 0) begin
          c = $urandom_range(0, 1) ? 8'(";") : 8'($urandom);
          while (hex_digit(c) >= 0) c = 8'($urandom);
        end else begin
          c = 8'($urandom);
          while (line[$] == CHAR_CR && c == CHAR_LF) c = 8'($urandom);
        end
        line.push_back(c);
      end
    end
    line.push_back(CHAR_CR);
    line.push_back(CHAR_LF);
    foreach (line[i]) send_byte(line[i]);
    repeat (len) send_byte(8'($urandom));
  endtask

  // cr lf as the first two bytes is skipped whitespace, then byte extremes as payload
  task automatic test_short_crlf_line();
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_line("2");
    send_byte(8'h00);
    send_byte(8'hff);
  endtask

  // a line of exactly the maximum length still ends normally
  task automatic test_full_length_line();
    send_byte(CHAR_SP);
    send_byte(CHAR_TAB);
    send_line("000001");
    send_byte(8'h80);
  endtask

  // a lone cr inside the line stops the parse but does not end the line
  task automatic test_stray_cr_line();
    send_byte("1");
    send_byte(CHAR_CR);
    send_byte("Z");
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_byte(8'h7f);
  endtask

  // receiver holds off for a long stretch while the sender keeps offering beats
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_asks++;
    send_chunk(12, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_chunks(input int idle_pct, input int stall_pct, input int n);
    int start;
    int len;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < n) begin
      // mostly short chunks, the odd long one
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
      send_chunk(len, $urandom_range(0, 2) == 0);
    end
    wait_drained();
  endtask

  // the body can end only once per run: zero size, zero via prefix or sign, or overlong line
  task automatic test_body_end();
    send_idle_pct = 8;
    recv_stall_pct = 8;
    case ($urandom_range(0, 3))
      0: send_line("0");
      1: send_line("0x1f");
      2: send_line("+7");
      default: send_line("123456789");
    endcase
    // every later byte keeps the sticky end or error
    repeat (16) send_byte(8'($urandom));
  endtask

  // receiver: random stalls, plus the long hold-off counted down here
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // checker: each accepted result beat against the oldest prediction
  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (exp_beats.size() == 0) begin
        report_mismatch("beat with nothing expected, kind", 32'(out_kind), 32'h0);
      end else begin
        e = exp_beats.pop_front();
        if (out_kind !== e.kind) report_mismatch("out_kind", 32'(out_kind), 32'(e.kind));
        if (out_byte !== e.data) report_mismatch("out_byte", 32'(out_byte), 32'(e.data));
        if (out_chunk_last !== e.last) begin
          report_mismatch("out_chunk_last", 32'(out_chunk_last), 32'(e.last));
        end
      end
      beats_seen++;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_crlf_line();
    test_full_length_line();
    test_stray_cr_line();
    wait_drained();
    test_output_stall();

    // idling phases: none, sender gaps, receiver stalls, both light
    test_random_chunks(0, 0, 150);
    test_random_chunks(51, 0, 150);
    test_random_chunks(0, 51, 150);
    test_random_chunks(8, 8, 150);

    test_body_end();
    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: http_chunked_body_decoder.f
design/hcd_pkg.sv
design/hcd_size_parse.sv
design/http_chunked_body_decoder.sv
tb/sv/http_chunked_body_decoder_tb.sv
